### rtl/core/sdx_pkg.sv
// ----------------------------------------------------------------------------
// sdx_pkg
// Shared types and constants of the strided read descriptor expander.
// ----------------------------------------------------------------------------
package sdx_pkg;

   // table depth must be a power of two: indices wrap on their low bits
   localparam int CORE_TABLE_DEPTH = 64;
   localparam int MAX_STRIDES      = 64;

   localparam int TABLE_ADDR_BITS = $clog2(CORE_TABLE_DEPTH);
   localparam int COUNT_BITS      = $clog2(MAX_STRIDES + 1);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [7:0] SKIP_CODE = 8'h01;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_LOAD_X = 2'd1,
      ACT_LOAD_Y = 2'd2,
      ACT_EXPAND = 2'd3
   } action_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_UNIT_BYTES       = 3'd0,
      CSR_PAGE_BYTES       = 3'd1,
      CSR_SOURCE_BASE      = 3'd2,
      CSR_DEST_BASE        = 3'd3,
      CSR_DEST_PAGE_OFFSET = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [15:0] unit_bytes;
      logic [15:0] page_bytes;
      logic [31:0] source_base;
      logic [31:0] dest_base;
      logic [15:0] dest_page_offset;
   } cfg_type;

endpackage

### rtl/core/sdx_csr_regs.sv
// ----------------------------------------------------------------------------
// sdx_csr_regs
// Configuration registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module sdx_csr_regs
   import sdx_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_UNIT_BYTES:       cfg_in.unit_bytes       = csr_write_data[15:0];
            CSR_PAGE_BYTES:       cfg_in.page_bytes       = csr_write_data[15:0];
            CSR_SOURCE_BASE:      cfg_in.source_base      = csr_write_data[31:0];
            CSR_DEST_BASE:        cfg_in.dest_base        = csr_write_data[31:0];
            CSR_DEST_PAGE_OFFSET: cfg_in.dest_page_offset = csr_write_data[15:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_bytes       <= 16'd1;
         cfg_ff.page_bytes       <= 16'd1;
         cfg_ff.source_base      <= 32'd0;
         cfg_ff.dest_base        <= 32'd0;
         cfg_ff.dest_page_offset <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/sdx_mul_unit.sv
// ----------------------------------------------------------------------------
// sdx_mul_unit
// Shared 32 x 16 multiplier, low 32 bits of the product registered.
// ----------------------------------------------------------------------------
module sdx_mul_unit
   import sdx_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [15:0] op_b,
   output logic [31:0] product
);

   logic [47:0] full_product;
   logic [31:0] product_ff;

   assign full_product = {16'd0, op_a} * {32'd0, op_b};

   always_ff @(posedge clock) begin
      product_ff <= full_product[31:0];
   end

   assign product = product_ff;

endmodule

### rtl/core/sdx_coord_table.sv
// ----------------------------------------------------------------------------
// sdx_coord_table
// Core coordinate table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sdx_coord_table
   import sdx_pkg::*;
(
   input  logic                       clock,
   input  logic                       write_enable,
   input  logic [TABLE_ADDR_BITS-1:0] write_addr,
   input  logic [7:0]                 write_data,
   input  logic [TABLE_ADDR_BITS-1:0] read_addr,
   output logic [7:0]                 read_data
);

   logic [7:0] mem [CORE_TABLE_DEPTH];
   logic [7:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

### rtl/core/strided_read_descriptor_expander.sv
// ----------------------------------------------------------------------------
// strided_read_descriptor_expander
// Expands stride-pattern entries into remote-read descriptors, one per stride,
// using a single shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   ports                       handshake
//  request   req_*                       start & !busy
//  response  rsp_*                       rsp_valid, one cycle, no back-pressure
//  config    csr_*                       csr_write_enable
//
//  load x/y: busy stays low.
//  start: busy through ST_START_MUL and ST_START_SUM (one multiply, one add).
//  expand: busy setup states on the shared multiplier, then one descriptor per
//  cycle, min(stride count, MAX_STRIDES) of them.
//  reset is synchronous; tables are not cleared, destination pointer goes to 0.
//  descriptors cannot be stalled: each is offered for exactly one cycle.
// ----------------------------------------------------------------------------
module strided_read_descriptor_expander
   import sdx_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_action,
   input  logic [5:0]                req_table_index,
   input  logic [7:0]                req_coord_value,
   input  logic [31:0]               req_meta_core_word,
   input  logic [31:0]               req_meta_data_word,
   input  logic [31:0]               req_core_start_word,
   input  logic [31:0]               req_data_offset_word,
   input  logic [31:0]               req_size_count_word,
   input  logic [15:0]               req_repeat_index,

   output logic                      rsp_valid,
   output logic [7:0]                rsp_core_x,
   output logic [7:0]                rsp_core_y,
   output logic [31:0]               rsp_source_addr,
   output logic [31:0]               rsp_dest_addr,
   output logic [31:0]               rsp_length_bytes,
   output logic                      rsp_read_enable,
   output logic                      rsp_last,

   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START_MUL,
      ST_START_SUM,
      ST_MUL_LEN,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_D,
      ST_SUM,
      ST_MUL_OFF,
      ST_WAIT_OFF,
      ST_EMIT
   } state_type;

   cfg_type cfg;

   state_type             state_ff,       state_in;
   logic [31:0]           dest_ptr_ff,    dest_ptr_in;
   logic [31:0]           meta_core_ff,   meta_core_in;
   logic [31:0]           meta_data_ff,   meta_data_in;
   logic [31:0]           core_start_ff,  core_start_in;
   logic [31:0]           data_off_ff,    data_off_in;
   logic [15:0]           units_ff,       units_in;
   logic                  skip_ff,        skip_in;
   logic [15:0]           rep_ff,         rep_in;
   logic [COUNT_BITS-1:0] remain_ff,      remain_in;
   logic [31:0]           len_ff,         len_in;
   logic [31:0]           xi_ff,          xi_in;
   logic [31:0]           yi_ff,          yi_in;
   logic [31:0]           sum_ff,         sum_in;
   logic [31:0]           adv_ff,         adv_in;
   logic [31:0]           src_ff,         src_in;

   logic        accept;
   logic [31:0] mul_a;
   logic [15:0] mul_b;
   logic [31:0] product;
   logic [31:0] count_raw;
   logic [31:0] count_clamped;
   logic [31:0] table_index_ext;
   logic [TABLE_ADDR_BITS-1:0] write_addr;
   logic        write_x;
   logic        write_y;
   logic [7:0]  x_read;
   logic [7:0]  y_read;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign table_index_ext = {26'd0, req_table_index};
   assign write_addr      = table_index_ext[TABLE_ADDR_BITS-1:0];
   assign write_x = accept && (action_type'(req_action) == ACT_LOAD_X);
   assign write_y = accept && (action_type'(req_action) == ACT_LOAD_Y);

   assign count_raw     = {24'd0, req_size_count_word[15:8]};
   assign count_clamped = (count_raw > 32'(MAX_STRIDES)) ? 32'(MAX_STRIDES) : count_raw;

   sdx_csr_regs u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   sdx_mul_unit u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   // read ports follow the next index, so read data always matches xi_ff / yi_ff
   sdx_coord_table u_x_table (
      .clock        (clock),
      .write_enable (write_x),
      .write_addr   (write_addr),
      .write_data   (req_coord_value),
      .read_addr    (xi_in[TABLE_ADDR_BITS-1:0]),
      .read_data    (x_read)
   );

   sdx_coord_table u_y_table (
      .clock        (clock),
      .write_enable (write_y),
      .write_addr   (write_addr),
      .write_data   (req_coord_value),
      .read_addr    (yi_in[TABLE_ADDR_BITS-1:0]),
      .read_data    (y_read)
   );

   always_comb begin
      state_in      = state_ff;
      dest_ptr_in   = dest_ptr_ff;
      meta_core_in  = meta_core_ff;
      meta_data_in  = meta_data_ff;
      core_start_in = core_start_ff;
      data_off_in   = data_off_ff;
      units_in      = units_ff;
      skip_in       = skip_ff;
      rep_in        = rep_ff;
      remain_in     = remain_ff;
      len_in        = len_ff;
      xi_in         = xi_ff;
      yi_in         = yi_ff;
      sum_in        = sum_ff;
      adv_in        = adv_ff;
      src_in        = src_ff;
      mul_a         = 32'd0;
      mul_b         = 16'd0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (action_type'(req_action))
                  ACT_START: state_in = ST_START_MUL;
                  ACT_EXPAND: begin
                     meta_core_in  = req_meta_core_word;
                     meta_data_in  = req_meta_data_word;
                     core_start_in = req_core_start_word;
                     data_off_in   = req_data_offset_word;
                     units_in      = req_size_count_word[31:16];
                     skip_in       = (req_size_count_word[7:0] == SKIP_CODE);
                     rep_in        = req_repeat_index;
                     remain_in     = count_clamped[COUNT_BITS-1:0];
                     state_in      = ST_MUL_LEN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_START_MUL: begin
            mul_a    = {16'd0, cfg.dest_page_offset};
            mul_b    = cfg.page_bytes;
            state_in = ST_START_SUM;
         end
         ST_START_SUM: begin
            dest_ptr_in = cfg.dest_base + product;
            state_in    = ST_IDLE;
         end
         ST_MUL_LEN: begin
            mul_a    = {16'd0, units_ff};
            mul_b    = cfg.unit_bytes;
            state_in = ST_MUL_X;
         end
         ST_MUL_X: begin
            mul_a    = {16'd0, meta_core_ff[31:16]};
            mul_b    = rep_ff;
            len_in   = product;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            mul_a    = {16'd0, meta_core_ff[15:0]};
            mul_b    = rep_ff;
            xi_in    = {24'd0, core_start_ff[31:24]} + product;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            mul_a    = meta_data_ff;
            mul_b    = rep_ff;
            yi_in    = {24'd0, core_start_ff[23:16]} + product;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            mul_a    = {16'd0, data_off_ff[31:16]};
            mul_b    = cfg.unit_bytes;
            sum_in   = {16'd0, data_off_ff[15:0]} + product;
            state_in = ST_MUL_OFF;
         end
         ST_MUL_OFF: begin
            mul_a = sum_ff;
            mul_b = cfg.unit_bytes;
            // with no core movement the source walks on past each stride
            if (core_start_ff[15:0] == 16'd0) begin
               adv_in = product + len_ff;
            end else begin
               adv_in = product;
            end
            state_in = ST_WAIT_OFF;
         end
         ST_WAIT_OFF: begin
            src_in = cfg.source_base + product;
            if (remain_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            dest_ptr_in = dest_ptr_ff + len_ff;
            src_in      = src_ff + adv_ff;
            xi_in       = xi_ff + {24'd0, core_start_ff[15:8]};
            yi_in       = yi_ff + {24'd0, core_start_ff[7:0]};
            remain_in   = remain_ff - COUNT_BITS'(1);
            if (remain_ff == COUNT_BITS'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         dest_ptr_ff <= 32'd0;
         remain_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         dest_ptr_ff <= dest_ptr_in;
         remain_ff   <= remain_in;
      end
      meta_core_ff  <= meta_core_in;
      meta_data_ff  <= meta_data_in;
      core_start_ff <= core_start_in;
      data_off_ff   <= data_off_in;
      units_ff      <= units_in;
      skip_ff       <= skip_in;
      rep_ff        <= rep_in;
      len_ff        <= len_in;
      xi_ff         <= xi_in;
      yi_ff         <= yi_in;
      sum_ff        <= sum_in;
      adv_ff        <= adv_in;
      src_ff        <= src_in;
   end

   assign rsp_valid        = (state_ff == ST_EMIT);
   assign rsp_core_x       = skip_ff ? 8'd0 : x_read;
   assign rsp_core_y       = skip_ff ? 8'd0 : y_read;
   assign rsp_source_addr  = src_ff;
   assign rsp_dest_addr    = dest_ptr_ff;
   assign rsp_length_bytes = len_ff;
   assign rsp_read_enable  = !skip_ff;
   assign rsp_last         = rsp_valid && (remain_ff == COUNT_BITS'(1));

   // a transaction's descriptors come out back to back and end on last
   a_burst_continues : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("descriptor burst broken before last");

   a_last_ends_burst : assert property (@(posedge clock) disable iff (reset)
      rsp_last |=> !rsp_valid && !busy)
      else $error("descriptor after last");

   a_dest_advances : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=>
         rsp_dest_addr == $past(rsp_dest_addr) + $past(rsp_length_bytes))
      else $error("destination pointer did not advance by stride length");

   a_no_accept_in_burst : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("descriptor issued while idle");

endmodule
